### sv/srf_pkg.sv
package srf_pkg;

  // Request modes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_FAST  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam int READ_BYTES_DEF = 4;
  localparam int PAY_MAX        = 4;
  localparam int HDR_MAX        = 2;
  localparam int FRAME_MAX      = HDR_MAX + PAY_MAX;
  localparam int CNT_W          = $clog2(FRAME_MAX + 1);

  localparam logic [7:0] HDR_WRITE_BIT = 8'h80;
  localparam logic [7:0] HDR_LONG_BIT  = 8'h40;
  localparam logic [7:0] FAST_CMD_BITS = 8'h81;

  typedef struct packed {
    logic [FRAME_MAX-1:0][7:0] bytes;
    logic [FRAME_MAX-1:0]      dummy;
    logic [CNT_W-1:0]          len;
  } frame_t;

endpackage

### sv/srf_stages.sv
module srf_stages #(
  parameter int READ_BYTES = srf_pkg::READ_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      mode,
  input  logic [4:0]      base_addr,
  input  logic [6:0]      reg_offset,
  input  logic [31:0]     write_value,
  input  logic [2:0]      byte_count,
  input  logic [4:0]      command_code,
  output logic            frame_valid,
  input  logic            frame_ready,
  output srf_pkg::frame_t frame
);
  import srf_pkg::*;

  localparam logic [CNT_W-1:0] READ_CNT = CNT_W'(READ_BYTES);
  localparam logic [CNT_W-1:0] PAY_CNT  = CNT_W'(PAY_MAX);

  // Stage 1: captured request
  logic        s1_valid;
  logic [1:0]  s1_mode;
  logic [4:0]  s1_base;
  logic [6:0]  s1_sub;
  logic [31:0] s1_data;
  logic [2:0]  s1_cnt;
  logic [4:0]  s1_cmd;

  // Stage 2: header bytes and payload length
  logic             s2_valid;
  logic             s2_read;
  logic             s2_long;
  logic [7:0]       s2_hdr0;
  logic [7:0]       s2_hdr1;
  logic [CNT_W-1:0] s2_npay;
  logic [31:0]      s2_data;

  // Stage 3: assembled frame
  logic   s3_valid;
  frame_t s3_frame;

  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready = !s3_valid || frame_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;

  // Stage 1 -------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      // drop undefined mode here, it produces no bytes
      s1_valid <= in_valid && (mode != MODE_NONE);
    end
    if (s1_ready && in_valid) begin
      s1_mode <= mode;
      s1_base <= base_addr;
      s1_sub  <= reg_offset;
      s1_data <= write_value;
      s1_cnt  <= byte_count;
      s1_cmd  <= command_code;
    end
  end

  // Stage 2 -------------------------------------------------------------
  logic             hdr_long;
  logic [7:0]       hdr0_next;
  logic [7:0]       hdr1_next;
  logic [CNT_W-1:0] min_len;
  logic [CNT_W-1:0] npay_next;

  always_comb begin
    hdr_long  = (s1_sub != 7'd0);
    hdr0_next = {2'b00, s1_base, 1'b0};
    hdr1_next = {s1_sub[5:0], 2'b00};
    if (s1_mode == MODE_WRITE) begin
      hdr0_next = hdr0_next | HDR_WRITE_BIT;
    end
    if (hdr_long) begin
      hdr0_next = hdr0_next | HDR_LONG_BIT | {7'd0, s1_sub[6]};
    end

    if (s1_data[31:24] != 8'd0) begin
      min_len = CNT_W'(4);
    end else if (s1_data[23:16] != 8'd0) begin
      min_len = CNT_W'(3);
    end else if (s1_data[15:8] != 8'd0) begin
      min_len = CNT_W'(2);
    end else begin
      min_len = CNT_W'(1);
    end

    case (s1_mode)
      MODE_READ:  npay_next = READ_CNT;
      MODE_WRITE: begin
        if (s1_cnt == 3'd0) begin
          npay_next = min_len;
        end else if (s1_cnt inside {[3'd5:3'd7]}) begin
          npay_next = PAY_CNT;
        end else begin
          npay_next = CNT_W'(s1_cnt);
        end
      end
      default: npay_next = '0;
    endcase

    // fast command is one header-like byte with no payload
    if (s1_mode == MODE_FAST) begin
      hdr0_next = FAST_CMD_BITS | {2'b00, s1_cmd, 1'b0};
      hdr_long  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      s2_read <= (s1_mode == MODE_READ);
      s2_long <= hdr_long;
      s2_hdr0 <= hdr0_next;
      s2_hdr1 <= hdr1_next;
      s2_npay <= npay_next;
      s2_data <= s1_data;
    end
  end

  // Stage 3 -------------------------------------------------------------
  frame_t frame_next;

  always_comb begin
    frame_next          = '0;
    frame_next.bytes[0] = s2_hdr0;
    if (s2_long) begin
      frame_next.bytes[1] = s2_hdr1;
    end
    for (int p = 0; p < PAY_MAX; p++) begin
      if (s2_long) begin
        frame_next.bytes[p + 2] = s2_read ? 8'h00 : s2_data[p*8 +: 8];
        frame_next.dummy[p + 2] = s2_read;
      end else begin
        frame_next.bytes[p + 1] = s2_read ? 8'h00 : s2_data[p*8 +: 8];
        frame_next.dummy[p + 1] = s2_read;
      end
    end
    frame_next.len = s2_npay + (s2_long ? CNT_W'(2) : CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
    if (s3_ready && s2_valid) begin
      s3_frame <= frame_next;
    end
  end

  assign frame_valid = s3_valid;
  assign frame       = s3_frame;

endmodule

### sv/srf_serializer.sv
module srf_serializer (
  input  logic            clk,
  input  logic            rst,
  input  logic            frame_valid,
  output logic            frame_ready,
  input  srf_pkg::frame_t frame,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      spi_byte,
  output logic            is_dummy,
  output logic            last
);
  import srf_pkg::*;

  logic                      ser_valid;
  logic [FRAME_MAX-1:0][7:0] ser_bytes;
  logic [FRAME_MAX-1:0]      ser_dummy;
  logic [CNT_W-1:0]          ser_left;

  logic out_free;
  logic ser_last;

  assign out_free    = !out_valid || !out_stall;
  assign ser_last    = (ser_left == CNT_W'(1));
  assign frame_ready = !ser_valid || (out_free && ser_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= ser_valid;
      end
      if (frame_ready) begin
        ser_valid <= frame_valid;
      end
    end

    if (frame_ready && frame_valid) begin
      ser_bytes <= frame.bytes;
      ser_dummy <= frame.dummy;
      ser_left  <= frame.len;
    end else if (ser_valid && out_free) begin
      // advance to the next byte of the frame
      ser_bytes <= ser_bytes >> 8;
      ser_dummy <= ser_dummy >> 1;
      ser_left  <= ser_left - CNT_W'(1);
    end

    if (ser_valid && out_free) begin
      spi_byte <= ser_bytes[0];
      is_dummy <= ser_dummy[0];
      last     <= ser_last;
    end
  end

  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    ser_valid |-> (ser_left != '0) && (ser_left <= CNT_W'(FRAME_MAX)))
    else $error("serializer holds a frame with bad byte count");

  a_load_len: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_ready |-> (frame.len != '0))
    else $error("empty frame handed to serializer");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("gap inside a transaction");

  a_dummy_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_dummy |-> (spi_byte == 8'h00) && !$past(rst))
    else $error("dummy beat carries nonzero data");

endmodule

### sv/spi_register_access_framer_top.sv
// SPI register access framer: each request beat (register read, register
// write or fast command) becomes a run of output beats, one SPI byte each,
// with last set on the final byte and is_dummy set on the zero bytes of a
// read. A request produces 1 byte for a fast command, header (1 or 2) plus
// READ_BYTES for a read, and header plus 1 to 4 payload bytes for a write;
// bytes leave one per cycle, unless out_stall holds them, through a single
// output byte register fed by a frame shift register. Requests enter a
// three-stage pipeline (capture, header and length, frame assembly) that
// takes a new beat every cycle while it has room; the first byte then passes
// the frame shift register and the output byte register. Mode 3 is accepted and dropped.
module spi_register_access_framer_top #(
  parameter int READ_BYTES = srf_pkg::READ_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [4:0]  base_addr,
  input  logic [6:0]  reg_offset,
  input  logic [31:0] write_value,
  input  logic [2:0]  byte_count,
  input  logic [4:0]  command_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  spi_byte,
  output logic        is_dummy,
  output logic        last
);
  import srf_pkg::*;

  logic   frame_valid;
  logic   frame_ready;
  frame_t frame;

  srf_stages #(
    .READ_BYTES (READ_BYTES)
  ) u_stages (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .base_addr    (base_addr),
    .reg_offset   (reg_offset),
    .write_value  (write_value),
    .byte_count   (byte_count),
    .command_code (command_code),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame        (frame)
  );

  srf_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .spi_byte    (spi_byte),
    .is_dummy    (is_dummy),
    .last        (last)
  );

endmodule

### sim/spi_register_access_framer_checker.sv
`timescale 1ns / 1ps

module spi_register_access_framer_checker #(
  parameter int READ_BYTES = srf_pkg::READ_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [4:0]  base_addr,
  input  logic [6:0]  reg_offset,
  input  logic [31:0] write_value,
  input  logic [2:0]  byte_count,
  input  logic [4:0]  command_code,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  spi_byte,
  input  logic        is_dummy,
  input  logic        last,
  output int          fail_count,
  output int          bytes_pending
);
  import srf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       dummy;
    logic       fin;
  } spi_beat_t;

  spi_beat_t bytes_due[$];

  // Expand one request into the SPI bytes it must produce.
  task automatic build_frame(input logic [1:0] m, input logic [4:0] base,
                             input logic [6:0] sub, input logic [31:0] value,
                             input logic [2:0] cnt, input logic [4:0] cmd);
    logic [7:0] hdr0;
    logic [7:0] hdr1;
    int nhdr;
    int npay;
    spi_beat_t beat;
    if (m == MODE_NONE) begin
      return;
    end
    if (m == MODE_FAST) begin
      beat.data  = FAST_CMD_BITS | {2'b00, cmd, 1'b0};
      beat.dummy = 1'b0;
      beat.fin   = 1'b1;
      bytes_due.push_back(beat);
      return;
    end
    hdr0 = ((m == MODE_WRITE) ? HDR_WRITE_BIT : 8'h00) | {2'b00, base, 1'b0};
    hdr1 = 8'h00;
    nhdr = 1;
    if (sub != 7'd0) begin
      hdr0 = hdr0 | HDR_LONG_BIT | {7'd0, sub[6]};
      hdr1 = {sub[5:0], 2'b00};
      nhdr = 2;
    end
    if (m == MODE_READ) begin
      npay = READ_BYTES;
    end else if (cnt == 3'd0) begin
      // shortest run of bytes that holds the value, never less than one
      if (value[31:24] != 8'd0) npay = 4;
      else if (value[23:16] != 8'd0) npay = 3;
      else if (value[15:8] != 8'd0) npay = 2;
      else npay = 1;
    end else begin
      npay = (cnt > PAY_MAX) ? PAY_MAX : cnt;
    end
    for (int i = 0; i < nhdr; i++) begin
      beat.data  = (i == 0) ? hdr0 : hdr1;
      beat.dummy = 1'b0;
      beat.fin   = (npay == 0) && (i == nhdr - 1);
      bytes_due.push_back(beat);
    end
    for (int i = 0; i < npay && i < PAY_MAX; i++) begin
      beat.data  = (m == MODE_READ) ? 8'h00 : value[8*i +: 8];
      beat.dummy = (m == MODE_READ);
      beat.fin   = (i == npay - 1);
      bytes_due.push_back(beat);
    end
  endtask

  always @(posedge clk) begin : watch
    spi_beat_t want;
    if (rst) begin
      fail_count    = 0;
      bytes_pending = 0;
    end else begin
      if (in_valid && !in_stall) begin
        build_frame(mode, base_addr, reg_offset, write_value, byte_count,
                    command_code);
      end
      if (out_valid && !out_stall) begin
        if (bytes_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected beat: spi_byte=%02h is_dummy=%0b last=%0b",
                     spi_byte, is_dummy, last);
          end
        end else begin
          want = bytes_due.pop_front();
          if (want.data !== spi_byte || want.dummy !== is_dummy ||
              want.fin !== last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display({"mismatch: expected byte=%02h dummy=%0b last=%0b,",
                        " got byte=%02h dummy=%0b last=%0b"},
                       want.data, want.dummy, want.fin, spi_byte, is_dummy, last);
            end
          end
        end
      end
      bytes_pending = bytes_due.size();
    end
  end

endmodule

### sim/tb_spi_register_access_framer_top.sv
`timescale 1ns / 1ps

module tb_spi_register_access_framer_top;
  import srf_pkg::*;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [1:0]  mode         = MODE_READ;
  logic [4:0]  base_addr    = 5'd0;
  logic [6:0]  reg_offset   = 7'd0;
  logic [31:0] write_value  = 32'd0;
  logic [2:0]  byte_count   = 3'd0;
  logic [4:0]  command_code = 5'd0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [7:0]  spi_byte;
  logic        is_dummy;
  logic        last;

  int   fail_count;
  int   bytes_pending;
  logic quiet = 1'b0;
  int   stall_hold = 0;

  always #5 clk = ~clk;

  spi_register_access_framer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .base_addr(base_addr), .reg_offset(reg_offset),
    .write_value(write_value), .byte_count(byte_count), .command_code(command_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .spi_byte(spi_byte), .is_dummy(is_dummy), .last(last)
  );

  spi_register_access_framer_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .base_addr(base_addr), .reg_offset(reg_offset),
    .write_value(write_value), .byte_count(byte_count), .command_code(command_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .spi_byte(spi_byte), .is_dummy(is_dummy), .last(last),
    .fail_count(fail_count), .bytes_pending(bytes_pending)
  );

  // mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_hold <= gap_len();
    end
  end

  // Present one request beat, hold it until taken, then idle for a random gap, possibly none.
  task automatic send_request(input logic [1:0] m, input logic [4:0] base,
                              input logic [6:0] sub, input logic [31:0] value,
                              input logic [2:0] cnt, input logic [4:0] cmd);
    int n;
    @(negedge clk);
    in_valid     <= 1'b1;
    mode         <= m;
    base_addr    <= base;
    reg_offset   <= sub;
    write_value  <= value;
    byte_count   <= cnt;
    command_code <= cmd;
    do @(posedge clk); while (in_stall);
    n = quiet ? 0 : gap_len();
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  initial begin
    #5_000_000;
    $display("spi_register_access_framer_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int waited;
    int r;
    logic [1:0]  m;
    logic [6:0]  sub;
    logic [31:0] value;
    logic [2:0]  cnt;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fast commands, with unused fields at both extremes
    send_request(MODE_FAST, 5'd0, 7'd0, 32'd0, 3'd0, 5'd0);
    send_request(MODE_FAST, 5'd31, 7'd127, 32'hFFFF_FFFF, 3'd7, 5'd31);
    // reads: short and long headers, sub-address bit 6 on and off, junk payload
    send_request(MODE_READ, 5'd0, 7'd0, 32'hFFFF_FFFF, 3'd7, 5'd31);
    send_request(MODE_READ, 5'd31, 7'd0, 32'd0, 3'd0, 5'd0);
    send_request(MODE_READ, 5'd31, 7'd127, 32'h1234_5678, 3'd2, 5'd9);
    send_request(MODE_READ, 5'd10, 7'd64, 32'd0, 3'd0, 5'd0);
    send_request(MODE_READ, 5'd21, 7'd63, 32'd0, 3'd4, 5'd0);
    // writes with minimal length taken from the value
    send_request(MODE_WRITE, 5'd31, 7'd0, 32'h0000_0000, 3'd0, 5'd0);
    send_request(MODE_WRITE, 5'd0, 7'd0, 32'h0000_00FF, 3'd0, 5'd31);
    send_request(MODE_WRITE, 5'd5, 7'd1, 32'h0000_0100, 3'd0, 5'd0);
    send_request(MODE_WRITE, 5'd17, 7'd127, 32'h0000_FFFF, 3'd0, 5'd0);
    send_request(MODE_WRITE, 5'd8, 7'd0, 32'h0001_0000, 3'd0, 5'd0);
    send_request(MODE_WRITE, 5'd30, 7'd64, 32'h00FF_FFFF, 3'd0, 5'd0);
    send_request(MODE_WRITE, 5'd1, 7'd0, 32'h0100_0000, 3'd0, 5'd0);
    send_request(MODE_WRITE, 5'd31, 7'd127, 32'hFFFF_FFFF, 3'd0, 5'd31);
    // explicit counts, then oversized counts that saturate
    send_request(MODE_WRITE, 5'd3, 7'd0, 32'hA5C3_5A3C, 3'd1, 5'd0);
    send_request(MODE_WRITE, 5'd12, 7'd33, 32'hA5C3_5A3C, 3'd2, 5'd0);
    send_request(MODE_WRITE, 5'd19, 7'd0, 32'h0000_0001, 3'd3, 5'd0);
    send_request(MODE_WRITE, 5'd26, 7'd90, 32'h0000_0000, 3'd4, 5'd0);
    send_request(MODE_WRITE, 5'd7, 7'd0, 32'h8765_4321, 3'd5, 5'd0);
    send_request(MODE_WRITE, 5'd9, 7'd2, 32'h0000_0012, 3'd6, 5'd0);
    send_request(MODE_WRITE, 5'd31, 7'd127, 32'hFFFF_FFFF, 3'd7, 5'd31);
    // undefined mode is taken and dropped
    send_request(MODE_NONE, 5'd31, 7'd127, 32'hFFFF_FFFF, 3'd7, 5'd31);

    sent = 0;
    while (sent < 125) begin
      if (sent % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      m = (r < 30) ? MODE_READ : (r < 75) ? MODE_WRITE : (r < 95) ? MODE_FAST : MODE_NONE;
      sub = ($urandom_range(0, 2) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
      value = $urandom;
      if ($urandom_range(0, 1) == 1) value = value >> $urandom_range(1, 31);
      if ($urandom_range(0, 9) == 0) value = 32'd0;
      cnt = ($urandom_range(0, 2) == 0) ? 3'd0 : 3'($urandom_range(0, 7));
      send_request(m, 5'($urandom_range(0, 31)), sub, value, cnt,
                   5'($urandom_range(0, 31)));
      if (m != MODE_NONE) sent++;
    end
    @(negedge clk);
    in_valid <= 1'b0;
    quiet = 1'b0;

    waited = 0;
    while (bytes_pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (12) @(posedge clk);

    if (fail_count == 0 && bytes_pending == 0) begin
      $display("spi_register_access_framer_top regression: pass");
    end else begin
      $display("spi_register_access_framer_top regression: fail");
    end
    $finish;
  end

endmodule

### files.f
sv/srf_pkg.sv
sv/srf_stages.sv
sv/srf_serializer.sv
sv/spi_register_access_framer_top.sv
sim/spi_register_access_framer_checker.sv
sim/tb_spi_register_access_framer_top.sv
